/* design/fspa_pkg.sv */
package fspa_pkg;

  parameter int unsigned DEFAULT_SLOTS = 1024;

  parameter int unsigned CMD_W     = 2;
  parameter int unsigned SLOT_W    = 10;
  parameter int unsigned STATUS_W  = 2;
  parameter int unsigned ADDR_W    = 32;
  parameter int unsigned COUNT_W   = 11;
  parameter int unsigned CHUNK_W   = 11;
  parameter int unsigned OBJ_W     = 13;
  parameter int unsigned CFG_W     = 32;
  parameter int unsigned CFG_IDX_W = 2;

  parameter logic [COUNT_W-1:0] COUNT_MAX   = '1;
  parameter logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(100);
  parameter logic [OBJ_W-1:0]   OBJ_RESET   = OBJ_W'(8);
  parameter logic [ADDR_W-1:0]  BASE_RESET  = '0;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_SIZE   = 2'd0,
    CFG_OBJECT_SIZE  = 2'd1,
    CFG_BASE_ADDRESS = 2'd2
  } cfg_idx_e;

endpackage

/* design/fspa_if.sv */
interface fspa_req_if;
  import fspa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] free_slot;

  modport source (output valid, output cmd, output free_slot, input ready);
  modport sink (input valid, input cmd, input free_slot, output ready);
endinterface

interface fspa_rsp_if;
  import fspa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [ADDR_W-1:0]   address;
  logic [COUNT_W-1:0]  in_use;

  modport source (output valid, output status, output slot, output address, output in_use,
                  input ready);
  modport sink (input valid, input status, input slot, input address, input in_use,
                output ready);
endinterface

/* design/fixed_slot_pool_allocator.sv */
// An allocate from a non-empty list loads its result transaction after a next-link read and
// a two-stage multiply-add address; when it replenishes the list it first writes one next
// link per slot of the new chunk. Any other command goes straight to its result transaction.
// One command is taken at a time: the next is accepted only once the result is loaded, and
// a waiting result transaction in the output register holds that load back.
// Reset (asynchronous, active low) empties the free list and clears all counts.
module fixed_slot_pool_allocator #(
  parameter int unsigned SLOTS = fspa_pkg::DEFAULT_SLOTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  fspa_req_if.sink                       req_i,
  fspa_rsp_if.source                     rsp_o,
  input  logic                           cfg_we_i,
  input  logic [fspa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fspa_pkg::CFG_W-1:0]     cfg_data_i
);
  import fspa_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);

  logic [CHUNK_W-1:0] chunk_size_q;
  logic [OBJ_W-1:0]   object_size_q;
  logic [ADDR_W-1:0]  base_address_q;

  logic              mem_we;
  logic [SlotW-1:0]  mem_waddr;
  logic [LinkW-1:0]  mem_wdata;
  logic              mem_re;
  logic [SlotW-1:0]  mem_raddr;
  logic [LinkW-1:0]  mem_rdata;
  logic              calc_start;
  logic [SlotW-1:0]  calc_slot;
  logic              calc_done;
  logic [ADDR_W-1:0] calc_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q   <= CHUNK_RESET;
      object_size_q  <= OBJ_RESET;
      base_address_q <= BASE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHUNK_SIZE:   chunk_size_q   <= cfg_data_i[CHUNK_W-1:0];
        CFG_OBJECT_SIZE:  object_size_q  <= cfg_data_i[OBJ_W-1:0];
        CFG_BASE_ADDRESS: base_address_q <= cfg_data_i[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fspa_ctrl #(
    .SLOTS(SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .chunk_size_i(chunk_size_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .calc_start_o(calc_start),
    .calc_slot_o (calc_slot),
    .calc_done_i (calc_done),
    .calc_addr_i (calc_addr)
  );

  fspa_link_ram #(
    .DEPTH(SLOTS),
    .WIDTH(LinkW)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  fspa_addr_calc #(
    .SLOTS(SLOTS)
  ) u_addr_calc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (calc_start),
    .slot_i       (calc_slot),
    .object_size_i(object_size_q),
    .base_i       (base_address_q),
    .done_o       (calc_done),
    .address_o    (calc_addr)
  );
endmodule

/* design/fspa_link_ram.sv */
module fspa_link_ram #(
  parameter int unsigned DEPTH = fspa_pkg::DEFAULT_SLOTS,
  parameter int unsigned WIDTH = $clog2(fspa_pkg::DEFAULT_SLOTS + 1)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* design/fspa_addr_calc.sv */
module fspa_addr_calc #(
  parameter int unsigned SLOTS = fspa_pkg::DEFAULT_SLOTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [$clog2(SLOTS)-1:0]     slot_i,
  input  logic [fspa_pkg::OBJ_W-1:0]   object_size_i,
  input  logic [fspa_pkg::ADDR_W-1:0]  base_i,
  output logic                         done_o,
  output logic [fspa_pkg::ADDR_W-1:0]  address_o
);
  import fspa_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned ProdW = SlotW + OBJ_W;

  logic             busy_q;
  logic             done_q;
  logic [ProdW-1:0] prod_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= ProdW'(slot_i) * ProdW'(object_size_i);
    end
    if (busy_q) begin
      addr_q <= base_i + ADDR_W'(prod_q);
    end
  end

  assign done_o    = done_q;
  assign address_o = addr_q;
endmodule

/* design/fspa_ctrl.sv */
module fspa_ctrl #(
  parameter int unsigned SLOTS = fspa_pkg::DEFAULT_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fspa_req_if.sink                      req_i,
  fspa_rsp_if.source                    rsp_o,
  input  logic [fspa_pkg::CHUNK_W-1:0]  chunk_size_i,
  output logic                          mem_we_o,
  output logic [$clog2(SLOTS)-1:0]      mem_waddr_o,
  output logic [$clog2(SLOTS+1)-1:0]    mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(SLOTS)-1:0]      mem_raddr_o,
  input  logic [$clog2(SLOTS+1)-1:0]    mem_rdata_i,
  output logic                          calc_start_o,
  output logic [$clog2(SLOTS)-1:0]      calc_slot_o,
  input  logic                          calc_done_i,
  input  logic [fspa_pkg::ADDR_W-1:0]   calc_addr_i
);
  import fspa_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam int unsigned SumW  = ((LinkW > CHUNK_W) ? LinkW : CHUNK_W) + 1;
  localparam int unsigned CmpW  = (LinkW > SLOT_W) ? LinkW : SLOT_W;
  localparam logic [LinkW-1:0] LinkEnd = LinkW'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CARVE,
    S_READ,
    S_LOOK,
    S_CALC,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [LinkW-1:0]   head_q, head_d;
  logic [LinkW-1:0]   carved_q, carved_d;
  logic [COUNT_W-1:0] in_use_q, in_use_d;
  logic [LinkW-1:0]   cur_q, cur_d;
  logic [LinkW-1:0]   last_q, last_d;
  status_e            res_status_q, res_status_d;
  logic               res_grant_q, res_grant_d;
  logic               out_valid_q, out_valid_d;
  status_e            out_status_q, out_status_d;
  logic [SLOT_W-1:0]  out_slot_q, out_slot_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [COUNT_W-1:0] out_in_use_q, out_in_use_d;

  logic            idle;
  logic [SumW-1:0] carve_end;
  logic            carve_ok;
  logic            free_ok;

  assign idle      = (state_q == S_IDLE);
  assign carve_end = SumW'(carved_q) + SumW'(chunk_size_i);
  assign carve_ok  = (chunk_size_i != '0) && (carve_end <= SumW'(SLOTS));
  assign free_ok   = CmpW'(req_i.free_slot) < CmpW'(carved_q);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    carved_d     = carved_q;
    in_use_d     = in_use_q;
    cur_d        = cur_q;
    last_d       = last_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_addr_d   = out_addr_q;
    out_in_use_d = out_in_use_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cur_q[SlotW-1:0];
    mem_wdata_o  = head_q;
    mem_re_o     = 1'b0;
    mem_raddr_o  = head_q[SlotW-1:0];
    calc_start_o = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          res_status_d = ST_OK;
          res_grant_d  = 1'b0;
          state_d      = S_DONE;
          unique case (req_i.cmd)
            CMD_ALLOC: begin
              if (head_q == LinkEnd) begin
                if (carve_ok) begin
                  cur_d    = carved_q;
                  last_d   = LinkW'(carve_end - SumW'(1));
                  head_d   = carved_q;
                  carved_d = LinkW'(carve_end);
                  state_d  = S_CARVE;
                end else begin
                  res_status_d = ST_OOM;
                end
              end else begin
                state_d = S_READ;
              end
            end
            CMD_FREE: begin
              if (free_ok) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = SlotW'(req_i.free_slot);
                mem_wdata_o = head_q;
                head_d      = LinkW'(req_i.free_slot);
                if (in_use_q != '0) begin
                  in_use_d = in_use_q - COUNT_W'(1);
                end
              end else begin
                res_status_d = ST_INVALID;
              end
            end
            CMD_RELEASE: begin
              head_d   = LinkEnd;
              carved_d = '0;
              in_use_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_CARVE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cur_q[SlotW-1:0];
        mem_wdata_o = (cur_q == last_q) ? LinkEnd : cur_q + LinkW'(1);
        cur_d       = cur_q + LinkW'(1);
        if (cur_q == last_q) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = head_q[SlotW-1:0];
        cur_d       = head_q;
        state_d     = S_LOOK;
      end
      S_LOOK: begin
        head_d = (mem_rdata_i > LinkEnd) ? LinkEnd : mem_rdata_i;
        if (in_use_q != COUNT_MAX) begin
          in_use_d = in_use_q + COUNT_W'(1);
        end
        calc_start_o = 1'b1;
        res_grant_d  = 1'b1;
        state_d      = S_CALC;
      end
      S_CALC: begin
        if (calc_done_i) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_grant_q ? SLOT_W'(cur_q) : '0;
          out_addr_d   = res_grant_q ? calc_addr_i : '0;
          out_in_use_d = in_use_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= LinkEnd;
      carved_q     <= '0;
      in_use_q     <= '0;
      cur_q        <= '0;
      last_q       <= '0;
      res_status_q <= ST_OK;
      res_grant_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_slot_q   <= '0;
      out_addr_q   <= '0;
      out_in_use_q <= '0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      carved_q     <= carved_d;
      in_use_q     <= in_use_d;
      cur_q        <= cur_d;
      last_q       <= last_d;
      res_status_q <= res_status_d;
      res_grant_q  <= res_grant_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_addr_q   <= out_addr_d;
      out_in_use_q <= out_in_use_d;
    end
  end

  assign calc_slot_o   = cur_q[SlotW-1:0];
  assign req_i.ready   = idle;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_status_q;
  assign rsp_o.slot    = out_slot_q;
  assign rsp_o.address = out_addr_q;
  assign rsp_o.in_use  = out_in_use_q;
endmodule

/* design/fspa_checker.sv */
module fspa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [fspa_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [fspa_pkg::SLOT_W-1:0]   rsp_slot_i,
  input logic [fspa_pkg::ADDR_W-1:0]   rsp_address_i,
  input logic [fspa_pkg::COUNT_W-1:0]  rsp_in_use_i
);
  import fspa_pkg::*;

  // A pending result transaction keeps its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
      $stable(rsp_slot_i) && $stable(rsp_address_i) && $stable(rsp_in_use_i))
    else $error("result payload changed while stalled");

  // The block works on one command at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("command accepted while busy");

  // Failed commands grant nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_OK) |-> (rsp_slot_i == '0) && (rsp_address_i == '0))
    else $error("slot or address reported on a failed command");
endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_slot_i   (rsp_o.slot),
  .rsp_address_i(rsp_o.address),
  .rsp_in_use_i (rsp_o.in_use)
);

/* test/fixed_slot_pool_allocator_tb.sv */
module fixed_slot_pool_allocator_tb;
  import fspa_pkg::*;

  localparam int unsigned SLOTS = DEFAULT_SLOTS;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  in_use;
  } pool_result_t;

  class pool_scoreboard;
    logic [COUNT_W-1:0] link_mem [SLOTS];
    int unsigned        head;
    int unsigned        carved;
    int unsigned        in_use;
    int unsigned        chunk;
    int unsigned        obj_size;
    logic [ADDR_W-1:0]  base;
    pool_result_t       pending_q[$];
    int unsigned        held_slots[$];
    int                 errors;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      head     = SLOTS;
      carved   = 0;
      in_use   = 0;
      chunk    = CHUNK_RESET;
      obj_size = OBJ_RESET;
      base     = BASE_RESET;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_CHUNK_SIZE:   chunk = data[CHUNK_W-1:0];
        CFG_OBJECT_SIZE:  obj_size = data[OBJ_W-1:0];
        CFG_BASE_ADDRESS: base = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Links the next chunk of never-used slots in ascending order.
    function bit carve();
      int unsigned first;
      first = carved;
      if (chunk == 0 || first > SLOTS || chunk > SLOTS - first) return 1'b0;
      for (int unsigned i = 0; i + 1 < chunk; i++) link_mem[first + i] = COUNT_W'(first + i + 1);
      link_mem[first + chunk - 1] = COUNT_W'(SLOTS);
      head   = first;
      carved = first + chunk;
      return 1'b1;
    endfunction

    function void note_input(logic [CMD_W-1:0] c, logic [SLOT_W-1:0] fs);
      pool_result_t r;
      int unsigned  s;
      int           idx;
      r.status  = ST_OK;
      r.slot    = '0;
      r.address = '0;
      idx       = -1;
      case (c)
        CMD_ALLOC: begin
          if (head >= SLOTS && !carve()) begin
            r.status = ST_OOM;
          end else if (head >= SLOTS) begin
            r.status = ST_OOM;
          end else begin
            s    = head;
            head = link_mem[s];
            if (head > SLOTS) head = SLOTS;
            if (in_use < COUNT_MAX) in_use++;
            r.slot    = SLOT_W'(s);
            r.address = base + ADDR_W'(s * obj_size);
            held_slots.push_back(s);
          end
        end
        CMD_FREE: begin
          if (fs >= carved) begin
            r.status = ST_INVALID;
          end else begin
            link_mem[fs] = COUNT_W'(head);
            head = fs;
            if (in_use > 0) in_use--;
            foreach (held_slots[i]) if (idx < 0 && held_slots[i] == fs) idx = i;
            if (idx >= 0) held_slots.delete(idx);
          end
        end
        CMD_RELEASE: begin
          head   = SLOTS;
          carved = 0;
          in_use = 0;
          held_slots.delete();
        end
        default: ;
      endcase
      r.in_use = COUNT_W'(in_use);
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] sl,
                               logic [ADDR_W-1:0] addr, logic [COUNT_W-1:0] cnt);
      pool_result_t e;
      if (pending_q.size() == 0) begin
        $error("result transaction with nothing expected: status %0d slot %0d", st, sl);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (sl !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, sl);
        errors++;
      end
      if (addr !== e.address) begin
        $error("address: expected %h, actual %h", e.address, addr);
        errors++;
      end
      if (cnt !== e.in_use) begin
        $error("in_use: expected %0d, actual %0d", e.in_use, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  fspa_req_if req ();
  fspa_rsp_if rsp ();

  fixed_slot_pool_allocator #(
    .SLOTS(SLOTS)
  ) uut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rsp_o     (rsp),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  pool_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  bit             hold_off_req = 1'b0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      sb.check_result(rsp.status, rsp.slot, rsp.address, rsp.in_use);
    end
  end

  initial begin : receiver
    rsp.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] fs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.cmd       <= c;
    req.free_slot <= fs;
    @(posedge clk_i);
    while (req.ready !== 1'b1) @(posedge clk_i);
    sb.note_input(c, fs);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] chunk, input logic [CFG_W-1:0] obj,
                            input logic [CFG_W-1:0] base);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CHUNK_SIZE;
    cfg_data_i <= chunk;
    @(posedge clk_i);
    sb.set_reg(CFG_CHUNK_SIZE, chunk);
    cfg_idx_i  <= CFG_OBJECT_SIZE;
    cfg_data_i <= obj;
    @(posedge clk_i);
    sb.set_reg(CFG_OBJECT_SIZE, obj);
    cfg_idx_i  <= CFG_BASE_ADDRESS;
    cfg_data_i <= base;
    @(posedge clk_i);
    sb.set_reg(CFG_BASE_ADDRESS, base);
    cfg_we_i   <= 1'b0;
  endtask

  // Mostly allocations and frees of granted slots, with some stray frees,
  // repeated frees, releases and unknown commands mixed in.
  task automatic run_random(input int unsigned n);
    int unsigned r;
    int unsigned pick;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 78 && sb.held_slots.size() == 0) ||
          (r >= 88 && r < 93 && sb.carved == 0)) begin
        send_item(CMD_ALLOC, SLOT_W'($urandom()));
      end else if (r < 78) begin
        pick = $urandom_range(0, sb.held_slots.size() - 1);
        send_item(CMD_FREE, SLOT_W'(sb.held_slots[pick]));
      end else if (r < 88) begin
        send_item(CMD_FREE, SLOT_W'($urandom()));
      end else if (r < 93) begin
        send_item(CMD_FREE, SLOT_W'($urandom_range(0, sb.carved - 1)));
      end else if (r < 96) begin
        send_item(CMD_RELEASE, SLOT_W'($urandom()));
      end else begin
        send_item(CMD_UNKNOWN, SLOT_W'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned      ph_chunk [NUM_PHASES];
    int unsigned      ph_obj   [NUM_PHASES];
    logic [ADDR_W-1:0] ph_base [NUM_PHASES];
    int unsigned      ph_send  [NUM_PHASES];
    int unsigned      ph_recv  [NUM_PHASES];
    ph_chunk = '{100, 1, 1024, 7, 37, 3};
    ph_obj   = '{8, 4096, 8, 8191, 13, 0};
    ph_base  = '{32'h0, 32'hFFFF_F000, $urandom(), 32'hFFFF_FFFF, $urandom(), $urandom()};
    ph_send  = '{0, 58, 0, 35, 0, 35};
    ph_recv  = '{0, 0, 58, 35, 0, 35};

    rst_ni        <= 1'b0;
    req.valid     <= 1'b0;
    req.cmd       <= CMD_ALLOC;
    req.free_slot <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_CHUNK_SIZE;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CMD_FREE, 10'd0);
    send_item(CMD_FREE, 10'd1023);
    send_item(CMD_UNKNOWN, 10'd1023);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_ALLOC, 10'd1023);
    send_item(CMD_FREE, 10'd1);
    send_item(CMD_FREE, 10'd0);
    send_item(CMD_FREE, 10'd0);
    send_item(CMD_FREE, 10'd100);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_RELEASE, 10'd1023);
    send_item(CMD_FREE, 10'd5);
    send_item(CMD_ALLOC, 10'd0);
    drain();
    set_config(32'd0, 32'd4096, 32'hFFFF_FFFF);
    send_item(CMD_RELEASE, 10'd0);
    send_item(CMD_ALLOC, 10'd0);
    drain();
    set_config(32'd1024, 32'd4096, 32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_FREE, 10'd1023);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_RELEASE, 10'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_config(ph_chunk[p], ph_obj[p], ph_base[p]);
      send_idle_pct  = ph_send[p];
      recv_stall_pct = ph_recv[p];
      if (ph_recv[p] == 58) hold_off_req = 1'b1;
      run_random(180);
      drain();
    end

    // Carve a single slot, then ask for a chunk that no longer fits beside it.
    // Freeing that slot twice links it to itself, so allocations keep returning it.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_config(32'd1, 32'd8, 32'h8000_0000);
    send_item(CMD_RELEASE, SLOT_W'($urandom()));
    send_item(CMD_ALLOC, SLOT_W'($urandom()));
    drain();
    set_config(32'd1024, 32'd8, 32'h8000_0000);
    send_item(CMD_ALLOC, SLOT_W'($urandom()));
    send_item(CMD_FREE, 10'd0);
    send_item(CMD_FREE, 10'd0);
    repeat (4) send_item(CMD_ALLOC, SLOT_W'($urandom()));
    send_item(CMD_RELEASE, SLOT_W'($urandom()));
    drain();

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
